### src/u2da_pkg.sv
`default_nettype none

package u2da_pkg;

    // Width of the input port and the number of its bits that are converted.
    localparam int IN_W        = 32;
    localparam int VALUE_WIDTH = 32;

    // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;

    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

    localparam int CHAR_W      = 6;
    localparam int COUNT_W     = 4;
    localparam int BCD_W       = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
    localparam logic [BCD_W-1:0]  BCD_ADJ_MIN = 4'd5;
    localparam logic [BCD_W-1:0]  BCD_ADJ     = 4'd3;

    typedef logic [BCD_W-1:0] t_bcd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } t_state;

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### src/u2da_cell.sv
`default_nettype none

module u2da_cell
    import u2da_pkg::*;
(
    input  wire             i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire             i_carry,
    input  wire t_bcd       i_digit,
    output logic            o_carry,
    output t_bcd            o_digit
);

    t_bcd r_digit;
    t_bcd n_digit;
    t_bcd adj;

    // Add three before the shift so that the digit wraps into the next cell at ten.
    always_comb begin
        if (r_digit >= BCD_ADJ_MIN) begin
            adj = r_digit + BCD_ADJ;
        end else begin
            adj = r_digit;
        end
        o_carry = adj[BCD_W-1];
    end

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_digit = {adj[BCD_W-2:0], i_carry};
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire

### src/unsigned_to_decimal_ascii.sv
`default_nettype none

// Converts one unsigned 32-bit word to its decimal ASCII digits, most significant
// first, without leading zeros (zero gives a single '0'). No terminator is sent.
// From the start pulse until busy drops, the value is first shifted one bit per
// cycle into a chain of ten BCD digit cells (shift-add-3), then the digit count
// is found, and then the chain shifts its digits out toward the top cell. Only
// the significant digits raise o_strobe, one per cycle in consecutive cycles, the
// final one with o_last. Every result is shown for one cycle only and cannot be
// held off, so the receiver must take it when o_strobe is high. A new word can be
// started in the first cycle in which busy is low.
module unsigned_to_decimal_ascii
    import u2da_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  wire [IN_W-1:0]     i_value,
    output logic               busy,
    output logic               o_strobe,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic [COUNT_W-1:0] o_digit_count,
    output logic               o_last
);

    t_state r_state;
    t_state n_state;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic [BIT_CNT_W-1:0]   r_bit;
    logic [BIT_CNT_W-1:0]   n_bit;
    logic [DIGIT_CNT_W-1:0] r_count;
    logic [DIGIT_CNT_W-1:0] n_count;
    logic [DIGIT_CNT_W-1:0] r_left;
    logic [DIGIT_CNT_W-1:0] n_left;
    logic [DIGIT_CNT_W-1:0] found_count;

    logic               r_strobe;
    logic               n_strobe;
    logic               r_last;
    logic               n_last;
    logic [CHAR_W-1:0]  r_char;
    logic [COUNT_W-1:0] r_count_out;

    logic       accept;
    logic       bit_done;
    logic       emit_done;
    t_cell_ctrl cell_ctrl;

    logic [NUM_DIGITS:0]   carry;
    t_bcd [NUM_DIGITS-1:0] digit;
    t_bcd [NUM_DIGITS-1:0] digit_in;

    assign accept    = start && (r_state == ST_IDLE);
    assign bit_done  = (r_bit == BIT_CNT_W'(VALUE_WIDTH - 1));
    assign emit_done = (r_left == DIGIT_CNT_W'(1));

    // The value enters the bottom cell most significant bit first.
    assign carry[0] = r_value[VALUE_WIDTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
            if (gi == 0) begin : g_bottom
                assign digit_in[gi] = '0;
            end else begin : g_upper
                assign digit_in[gi] = digit[gi-1];
            end

            u2da_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (cell_ctrl),
                .i_carry (carry[gi]),
                .i_digit (digit_in[gi]),
                .o_carry (carry[gi+1]),
                .o_digit (digit[gi])
            );
        end
    endgenerate

    // Highest nonzero digit sets the count; an all-zero chain still yields one digit.
    always_comb begin
        found_count = DIGIT_CNT_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (digit[i] != '0) begin
                found_count = DIGIT_CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bit_done) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cell_ctrl = '0;
        n_value   = r_value;
        n_bit     = r_bit;
        n_count   = r_count;
        n_left    = r_left;
        n_strobe  = 1'b0;
        n_last    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    cell_ctrl.clear = 1'b1;
                    n_value         = i_value[VALUE_WIDTH-1:0];
                    n_bit           = '0;
                end
            end
            ST_CONV: begin
                cell_ctrl.conv = 1'b1;
                n_value        = {r_value[VALUE_WIDTH-2:0], 1'b0};
                n_bit          = r_bit + BIT_CNT_W'(1);
            end
            ST_COUNT: begin
                n_count = found_count;
                n_left  = DIGIT_CNT_W'(NUM_DIGITS);
            end
            ST_EMIT: begin
                // Positions above the count are leading zeros and are shifted out silently.
                cell_ctrl.shift = 1'b1;
                n_left          = r_left - DIGIT_CNT_W'(1);
                n_strobe        = (r_left <= r_count);
                n_last          = emit_done;
            end
            default: begin
                cell_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_bit    <= '0;
            r_left   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bit    <= n_bit;
            r_left   <= n_left;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_char      <= ASCII_ZERO + CHAR_W'(digit[NUM_DIGITS-1]);
        r_count_out <= r_count[COUNT_W-1:0];
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_digit_char  = r_char;
    assign o_digit_count = r_count_out;
    assign o_last        = r_last;

    // A word only goes out from the shift-out phase.
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EMIT))
        else $error("digit word outside the shift-out phase");

    // The digits of one run leave in consecutive cycles up to the final one.
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a digit run");

    // The final flag never stands without a word.
    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("final flag without a digit word");

    // Shift-add-3 must keep every emitted digit a decimal digit.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_digit_char >= ASCII_ZERO) && (o_digit_char <= ASCII_NINE)))
        else $error("digit character out of range");

    // The chain is deep enough that nothing leaves the top cell.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !carry[NUM_DIGITS])
        else $error("carry out of the top digit cell");

endmodule

`default_nettype wire
